/* hdl/g2n_pkg.sv */
`default_nettype none
package g2n_pkg;

    typedef logic signed [31:0] angle_t;
    typedef logic signed [32:0] dlam_t;
    typedef logic signed [33:0] wide_angle_t;
    typedef logic signed [30:0] alt_t;
    typedef logic signed [31:0] dh_t;
    typedef logic signed [31:0] trig_t;
    typedef logic [32:0]        radius_t;
    typedef logic signed [34:0] radius_ext_t;
    typedef logic signed [52:0] mul_a_t;
    typedef logic signed [36:0] mul_b_t;
    typedef logic signed [55:0] mul_p_t;
    typedef logic [5:0]         shift_t;
    typedef logic signed [59:0] sum_t;
    typedef logic signed [36:0] offset_t;
    typedef logic [32:0]        cfg_data_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_LATITUDE     = 3'd0,
        REG_ORIGIN_LONGITUDE    = 3'd1,
        REG_ORIGIN_ALTITUDE     = 3'd2,
        REG_ORIGIN_SINE         = 3'd3,
        REG_ORIGIN_COSINE       = 3'd4,
        REG_MERIDIAN_RADIUS_ALT = 3'd5,
        REG_NORMAL_RADIUS       = 3'd6
    } cfg_reg_t;

    localparam wide_angle_t PI_Q      = 34'sd1686629713;
    localparam wide_angle_t TWO_PI_Q  = 34'sd3373259426;
    localparam wide_angle_t HALF_PI_Q = 34'sd843314857;

    localparam mul_b_t AE2_X3 = 37'sd128093019;
    localparam mul_a_t K16_CONST = 53'sd6378137000 * 53'sd65536
                                 + 53'sd42697673 * 53'sd32768;

    localparam trig_t   COSINE_RESET    = 32'sd1073741824;
    localparam radius_t MERIDIAN_RESET  = 33'd6335439327;
    localparam radius_t NORMAL_RESET    = 33'd6378137000;

    localparam sum_t OUT_MAX = 60'sd68719476735;
    localparam sum_t OUT_MIN = -60'sd68719476736;

    localparam int NUM_STAGES = 17;

    typedef struct packed {
        angle_t      olat;
        angle_t      olon;
        alt_t        h0;
        trig_t       s;
        trig_t       c;
        radius_t     rm;
        radius_ext_t rnh;
        radius_ext_t rnmh;
        mul_a_t      k16base;
    } cfg_t;

    function automatic angle_t wrap_angle(input angle_t x);
        wide_angle_t xe;
        wide_angle_t r;
        xe = wide_angle_t'(x);
        if (xe > PI_Q)
        begin
            r = xe - TWO_PI_Q;
        end
        else if (xe < -PI_Q)
        begin
            r = xe + TWO_PI_Q;
        end
        else
        begin
            r = xe;
        end
        return angle_t'(r);
    endfunction

    function automatic angle_t clamp_lat(input angle_t x);
        wide_angle_t xe;
        wide_angle_t r;
        xe = wide_angle_t'(x);
        if (xe > HALF_PI_Q)
        begin
            r = HALF_PI_Q;
        end
        else if (xe < -HALF_PI_Q)
        begin
            r = -HALF_PI_Q;
        end
        else
        begin
            r = xe;
        end
        return angle_t'(r);
    endfunction

endpackage
`default_nettype wire

/* hdl/g2n_cfg.sv */
`default_nettype none
module g2n_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  g2n_pkg::cfg_data_t  cfg_data,
    output g2n_pkg::cfg_t       cfg
);

    logic signed [30:0]    olat_raw_reg;
    g2n_pkg::angle_t       olon_raw_reg;
    g2n_pkg::alt_t         h0_reg;
    g2n_pkg::trig_t        s_reg;
    g2n_pkg::trig_t        c_reg;
    g2n_pkg::radius_t      rm_reg;
    g2n_pkg::radius_t      rn_reg;
    g2n_pkg::cfg_t         cfg_reg;
    g2n_pkg::cfg_t         cfg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            olat_raw_reg <= '0;
            olon_raw_reg <= '0;
            h0_reg       <= '0;
            s_reg        <= '0;
            c_reg        <= g2n_pkg::COSINE_RESET;
            rm_reg       <= g2n_pkg::MERIDIAN_RESET;
            rn_reg       <= g2n_pkg::NORMAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                g2n_pkg::REG_ORIGIN_LATITUDE:     olat_raw_reg <= $signed(cfg_data[30:0]);
                g2n_pkg::REG_ORIGIN_LONGITUDE:    olon_raw_reg <= $signed(cfg_data[31:0]);
                g2n_pkg::REG_ORIGIN_ALTITUDE:     h0_reg       <= $signed(cfg_data[30:0]);
                g2n_pkg::REG_ORIGIN_SINE:         s_reg        <= $signed(cfg_data[31:0]);
                g2n_pkg::REG_ORIGIN_COSINE:       c_reg        <= $signed(cfg_data[31:0]);
                g2n_pkg::REG_MERIDIAN_RADIUS_ALT: rm_reg       <= cfg_data;
                g2n_pkg::REG_NORMAL_RADIUS:       rn_reg       <= cfg_data;
                default:                          ;
            endcase
        end
    end

    // origin terms that depend on the registers alone
    always_comb
    begin
        cfg_next.olat = g2n_pkg::clamp_lat(g2n_pkg::wrap_angle(
                            g2n_pkg::angle_t'(olat_raw_reg)));
        cfg_next.olon = g2n_pkg::wrap_angle(olon_raw_reg);
        cfg_next.h0   = h0_reg;
        cfg_next.s    = s_reg;
        cfg_next.c    = c_reg;
        cfg_next.rm   = rm_reg;
        cfg_next.rnh  = $signed({2'b00, rn_reg}) + g2n_pkg::radius_ext_t'(h0_reg);
        cfg_next.rnmh = $signed({2'b00, rn_reg}) - g2n_pkg::radius_ext_t'(h0_reg);
        cfg_next.k16base = g2n_pkg::K16_CONST
                         + g2n_pkg::mul_a_t'($signed({h0_reg, 16'b0}));
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* hdl/g2n_mulsh.sv */
`default_nettype none
module g2n_mulsh (
    input  logic             clk,
    input  logic             en,
    input  g2n_pkg::mul_a_t  a,
    input  g2n_pkg::mul_b_t  b,
    input  g2n_pkg::shift_t  sh,
    output g2n_pkg::mul_p_t  p
);

    logic [52:0] a_abs_reg;
    logic [36:0] b_abs_reg;
    logic        neg1_reg;
    logic [63:0] plo_reg;
    logic [62:0] phi_reg;
    logic        neg2_reg;
    logic [54:0] mag_reg;
    logic        neg3_reg;
    g2n_pkg::mul_p_t p_reg;

    logic [52:0] a_abs_next;
    logic [36:0] b_abs_next;
    logic [89:0] full_next;
    logic [89:0] rnd;
    logic [89:0] shifted;

    // magnitudes, rounded half away from zero
    always_comb
    begin
        a_abs_next = a[52] ? (~a + 53'd1) : a;
        b_abs_next = b[36] ? (~b + 37'd1) : b;
        rnd        = 90'd1 << (sh - 6'd1);
        full_next  = {26'b0, plo_reg} + {phi_reg, 27'b0} + rnd;
        shifted    = full_next >> sh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_abs_reg <= a_abs_next;
            b_abs_reg <= b_abs_next;
            neg1_reg  <= a[52] ^ b[36];
            plo_reg   <= 64'(a_abs_reg[26:0] * b_abs_reg);
            phi_reg   <= 63'(a_abs_reg[52:27] * b_abs_reg);
            neg2_reg  <= neg1_reg;
            mag_reg   <= shifted[54:0];
            neg3_reg  <= neg2_reg;
            p_reg     <= neg3_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* hdl/geodetic_to_local_ned.sv */
// throughput: one beat per cycle when not stalled, set by three chained four-stage multiplier ranks
// a stalled output with a valid result holds the whole pipeline in place
// reset: clears the valid pipeline and loads the origin registers with defaults
// the origin-derived terms are registered and settle in the cycle after reset or a register write
`default_nettype none
module geodetic_to_local_ned (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  g2n_pkg::cfg_data_t  cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  g2n_pkg::angle_t     point_latitude,
    input  g2n_pkg::angle_t     point_longitude,
    input  g2n_pkg::alt_t       point_altitude,
    output logic                out_valid,
    input  logic                out_stall,
    output g2n_pkg::offset_t    north_offset,
    output g2n_pkg::offset_t    east_offset,
    output g2n_pkg::offset_t    down_offset,
    output logic                overflow_flag
);

    g2n_pkg::cfg_t cfg;
    logic          adv;
    logic [g2n_pkg::NUM_STAGES-1:0] vld_reg;

    g2n_pkg::angle_t lat_reg;
    g2n_pkg::angle_t lon_reg;
    g2n_pkg::alt_t   alt_reg;
    g2n_pkg::angle_t dphi_reg;
    g2n_pkg::dlam_t  dlam_reg;
    g2n_pkg::dh_t    dh_reg;
    g2n_pkg::angle_t dphi_next;
    g2n_pkg::dlam_t  dlam_next;
    g2n_pkg::dh_t    dh_next;
    g2n_pkg::angle_t lat_w;
    g2n_pkg::angle_t lon_w;

    g2n_pkg::dh_t    dh_pipe_reg   [2:14];
    g2n_pkg::dlam_t  dlam_pipe_reg [2:5];
    g2n_pkg::mul_p_t dphi2_pipe_reg[6:10];
    g2n_pkg::mul_p_t dlam2_pipe_reg[6:10];
    g2n_pkg::mul_p_t n1_pipe_reg   [6:14];
    g2n_pkg::mul_p_t e1_pipe_reg   [10:14];
    g2n_pkg::mul_p_t e3_pipe_reg   [10:14];

    g2n_pkg::mul_p_t sc, cc, dphi2, dlam2, spdphi, cpdlam, n1;
    g2n_pkg::mul_p_t ta, tb, tc, e1, td, e3, te, tf;
    g2n_pkg::mul_p_t n2, n3, n4, e2, d2, d3;

    g2n_pkg::mul_p_t ta_reg, tb_reg, tc_reg, td_reg, tf_reg;
    g2n_pkg::mul_a_t k16_reg;
    g2n_pkg::mul_a_t k16_next;

    g2n_pkg::sum_t   n_reg, e_reg, d_reg;
    g2n_pkg::sum_t   n_next, e_next, d_next;
    g2n_pkg::offset_t north_reg, east_reg, down_reg;
    g2n_pkg::offset_t north_next, east_next, down_next;
    logic            ovf_reg;
    logic            ovf_next;

    g2n_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign adv      = !(vld_reg[g2n_pkg::NUM_STAGES-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[g2n_pkg::NUM_STAGES-2:0], in_valid};
        end
    end

    // differences to the origin
    always_comb
    begin
        lat_w     = g2n_pkg::clamp_lat(g2n_pkg::wrap_angle(lat_reg));
        lon_w     = g2n_pkg::wrap_angle(lon_reg);
        dphi_next = g2n_pkg::angle_t'(g2n_pkg::dlam_t'(lat_w) - g2n_pkg::dlam_t'(cfg.olat));
        dlam_next = g2n_pkg::dlam_t'(lon_w) - g2n_pkg::dlam_t'(cfg.olon);
        dh_next   = g2n_pkg::dh_t'(alt_reg) - g2n_pkg::dh_t'(cfg.h0);
        k16_next  = g2n_pkg::mul_a_t'(g2n_pkg::sum_t'(cfg.k16base) - g2n_pkg::sum_t'(te));
    end

    // first rank
    g2n_mulsh u_sc (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.s)),
        .b(g2n_pkg::mul_b_t'(cfg.c)), .sh(6'd30), .p(sc));
    g2n_mulsh u_cc (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.c)),
        .b(g2n_pkg::mul_b_t'(cfg.c)), .sh(6'd30), .p(cc));
    g2n_mulsh u_dphi2 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(dphi_reg)),
        .b(g2n_pkg::mul_b_t'(dphi_reg)), .sh(6'd29), .p(dphi2));
    g2n_mulsh u_dlam2 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(dlam_reg)),
        .b(g2n_pkg::mul_b_t'(dlam_reg)), .sh(6'd29), .p(dlam2));
    g2n_mulsh u_spdphi (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(dphi_reg)),
        .b(g2n_pkg::mul_b_t'(cfg.s)), .sh(6'd30), .p(spdphi));
    g2n_mulsh u_cpdlam (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(dlam_reg)),
        .b(g2n_pkg::mul_b_t'(cfg.c)), .sh(6'd30), .p(cpdlam));
    g2n_mulsh u_n1 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.rm)),
        .b(g2n_pkg::mul_b_t'(dphi_reg)), .sh(6'd29), .p(n1));

    // second rank
    g2n_mulsh u_ta (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(sc)),
        .b(g2n_pkg::AE2_X3), .sh(6'd15), .p(ta));
    g2n_mulsh u_tb (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(dh_pipe_reg[5])),
        .b(g2n_pkg::mul_b_t'(spdphi)), .sh(6'd13), .p(tb));
    g2n_mulsh u_tc (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.rnh)),
        .b(g2n_pkg::mul_b_t'(sc)), .sh(6'd15), .p(tc));
    g2n_mulsh u_e1 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.rnh)),
        .b(g2n_pkg::mul_b_t'(cpdlam)), .sh(6'd29), .p(e1));
    g2n_mulsh u_td (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(spdphi)),
        .b(g2n_pkg::mul_b_t'(dlam_pipe_reg[5])), .sh(6'd29), .p(td));
    g2n_mulsh u_e3 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cpdlam)),
        .b(g2n_pkg::mul_b_t'(dh_pipe_reg[5])), .sh(6'd29), .p(e3));
    g2n_mulsh u_te (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cc)),
        .b(g2n_pkg::AE2_X3), .sh(6'd15), .p(te));
    g2n_mulsh u_tf (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.rnmh)),
        .b(g2n_pkg::mul_b_t'(cc)), .sh(6'd15), .p(tf));

    // third rank
    g2n_mulsh u_n2 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(ta_reg)),
        .b(g2n_pkg::mul_b_t'(dphi2_pipe_reg[10])), .sh(6'd45), .p(n2));
    g2n_mulsh u_n3 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(tb_reg)),
        .b(g2n_pkg::mul_b_t'(cfg.s)), .sh(6'd46), .p(n3));
    g2n_mulsh u_n4 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(tc_reg)),
        .b(g2n_pkg::mul_b_t'(dlam2_pipe_reg[10])), .sh(6'd45), .p(n4));
    g2n_mulsh u_e2 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(cfg.rm)),
        .b(g2n_pkg::mul_b_t'(td_reg)), .sh(6'd29), .p(e2));
    g2n_mulsh u_d2 (.clk(clk), .en(adv), .a(k16_reg),
        .b(g2n_pkg::mul_b_t'(dphi2_pipe_reg[10])), .sh(6'd46), .p(d2));
    g2n_mulsh u_d3 (.clk(clk), .en(adv), .a(g2n_pkg::mul_a_t'(tf_reg)),
        .b(g2n_pkg::mul_b_t'(dlam2_pipe_reg[10])), .sh(6'd45), .p(d3));

    // sums and saturation
    always_comb
    begin
        n_next = g2n_pkg::sum_t'(n1_pipe_reg[14]) + g2n_pkg::sum_t'(n2)
               + g2n_pkg::sum_t'(n3) + g2n_pkg::sum_t'(n4);
        e_next = g2n_pkg::sum_t'(e1_pipe_reg[14]) - g2n_pkg::sum_t'(e2)
               + g2n_pkg::sum_t'(e3_pipe_reg[14]);
        d_next = g2n_pkg::sum_t'(d2) + g2n_pkg::sum_t'(d3)
               - g2n_pkg::sum_t'(dh_pipe_reg[14]);
        ovf_next = 1'b0;
        north_next = g2n_pkg::offset_t'(n_reg);
        east_next  = g2n_pkg::offset_t'(e_reg);
        down_next  = g2n_pkg::offset_t'(d_reg);
        if (n_reg > g2n_pkg::OUT_MAX)
        begin
            north_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MAX);
            ovf_next   = 1'b1;
        end
        else if (n_reg < g2n_pkg::OUT_MIN)
        begin
            north_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MIN);
            ovf_next   = 1'b1;
        end
        if (e_reg > g2n_pkg::OUT_MAX)
        begin
            east_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MAX);
            ovf_next  = 1'b1;
        end
        else if (e_reg < g2n_pkg::OUT_MIN)
        begin
            east_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MIN);
            ovf_next  = 1'b1;
        end
        if (d_reg > g2n_pkg::OUT_MAX)
        begin
            down_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MAX);
            ovf_next  = 1'b1;
        end
        else if (d_reg < g2n_pkg::OUT_MIN)
        begin
            down_next = g2n_pkg::offset_t'(g2n_pkg::OUT_MIN);
            ovf_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lat_reg  <= point_latitude;
            lon_reg  <= point_longitude;
            alt_reg  <= point_altitude;
            dphi_reg <= dphi_next;
            dlam_reg <= dlam_next;
            dh_reg   <= dh_next;

            dh_pipe_reg[2] <= dh_reg;
            for (int i = 3; i <= 14; i++)
            begin
                dh_pipe_reg[i] <= dh_pipe_reg[i-1];
            end
            dlam_pipe_reg[2] <= dlam_reg;
            for (int i = 3; i <= 5; i++)
            begin
                dlam_pipe_reg[i] <= dlam_pipe_reg[i-1];
            end
            dphi2_pipe_reg[6] <= dphi2;
            dlam2_pipe_reg[6] <= dlam2;
            for (int i = 7; i <= 10; i++)
            begin
                dphi2_pipe_reg[i] <= dphi2_pipe_reg[i-1];
                dlam2_pipe_reg[i] <= dlam2_pipe_reg[i-1];
            end
            n1_pipe_reg[6] <= n1;
            for (int i = 7; i <= 14; i++)
            begin
                n1_pipe_reg[i] <= n1_pipe_reg[i-1];
            end
            e1_pipe_reg[10] <= e1;
            e3_pipe_reg[10] <= e3;
            for (int i = 11; i <= 14; i++)
            begin
                e1_pipe_reg[i] <= e1_pipe_reg[i-1];
                e3_pipe_reg[i] <= e3_pipe_reg[i-1];
            end

            ta_reg  <= ta;
            tb_reg  <= tb;
            tc_reg  <= tc;
            td_reg  <= td;
            tf_reg  <= tf;
            k16_reg <= k16_next;

            n_reg <= n_next;
            e_reg <= e_next;
            d_reg <= d_next;

            north_reg <= north_next;
            east_reg  <= east_next;
            down_reg  <= down_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign out_valid     = vld_reg[g2n_pkg::NUM_STAGES-1];
    assign north_offset  = north_reg;
    assign east_offset   = east_reg;
    assign down_offset   = down_reg;
    assign overflow_flag = ovf_reg;

endmodule
`default_nettype wire
